// File: sv/thlr_pkg.sv
// ----------------------------------------------------------------------------
// thlr_pkg: shared types and constants of the thick line rasterizer
// Holds the command word that moves from the front part to the back part,
// the back part's state encoding and the slope class thresholds.
// ----------------------------------------------------------------------------
package thlr_pkg;

    // coordinate width of the request fields
    localparam int CW = 12;
    // working width of pixel coordinates (endpoint plus or minus half width)
    localparam int PW = 14;
    // width of the stepping error term (row delta times column delta)
    localparam int EW = 26;
    // request byte address width
    localparam int AAW = 17;

    // slope class thresholds in Q8: 2.414 and 0.414
    localparam int Q8_STEEP   = 618;
    localparam int Q8_SHALLOW = 106;

    // command queue depth
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = 1;

    typedef enum logic [1:0] {
        SEG_VERT,
        SEG_HORZ,
        SEG_GEN,
        REQ_READ
    } cmd_kind_t;

    // column offset of parallel copies
    typedef enum logic [1:0] {
        COFF_NONE,
        COFF_POS,
        COFF_NEG
    } coff_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic signed [CW-1:0]   fr;
        logic signed [CW-1:0]   fc;
        logic signed [CW-1:0]   tr;
        logic signed [CW-1:0]   tc;
        logic [2:0]             half;
        logic [AAW-1:0]         addr;
        logic                   rstep;
        coff_t                  coff;
        logic [CW-1:0]          dr;
        logic [CW-1:0]          adc;
        logic signed [CW-1:0]   max_row;
        logic signed [CW-1:0]   max_col;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_START,
        BK_BAND,
        BK_COPY,
        BK_WALK,
        BK_READ,
        BK_RESULT
    } back_state_t;

endpackage

// File: sv/thlr_front.sv
// ----------------------------------------------------------------------------
// thlr_front: request intake and classification
// Orders endpoints by row, updates the running maxima, classifies the
// segment and works out its slope class, then pushes one command word.
// ----------------------------------------------------------------------------
module thlr_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [71:0]         s_tdata,   // from_row, from_col, to_row, to_col,
                                           // line_width, read_addr, zero pad
    input  logic                s_tuser,   // req_type
    input  logic                q_full,
    input  logic                back_ready,
    output logic                q_push,
    output thlr_pkg::cmd_t      q_data
);

    logic signed [thlr_pkg::CW-1:0] from_row, from_col, to_row, to_col;
    logic [3:0]                     line_width;
    logic [thlr_pkg::AAW-1:0]       read_addr;
    logic                           swap;
    logic signed [thlr_pkg::CW-1:0] o_fr, o_fc, o_tr, o_tc;
    logic signed [thlr_pkg::CW-1:0] max_row_reg, max_row_next;
    logic signed [thlr_pkg::CW-1:0] max_col_reg, max_col_next;
    logic signed [thlr_pkg::CW:0]   drs, dcs;
    logic [thlr_pkg::CW-1:0]        dr, adc;
    logic [21:0]                    dr_q8, steep_p, shallow_p;

    // field unpack
    assign from_row   = $signed(s_tdata[11:0]);
    assign from_col   = $signed(s_tdata[23:12]);
    assign to_row     = $signed(s_tdata[35:24]);
    assign to_col     = $signed(s_tdata[47:36]);
    assign line_width = s_tdata[51:48];
    assign read_addr  = s_tdata[68:52];

    assign s_tready = !q_full && back_ready;
    assign q_push   = s_tvalid && s_tready;

    // order endpoints so the segment runs down the rows
    assign swap = to_row < from_row;
    assign o_fr = swap ? to_row   : from_row;
    assign o_fc = swap ? to_col   : from_col;
    assign o_tr = swap ? from_row : to_row;
    assign o_tc = swap ? from_col : to_col;

    // running maxima after this word
    always_comb begin
        max_row_next = max_row_reg;
        max_col_next = max_col_reg;
        if (!s_tuser) begin
            if (o_tr > max_row_next) max_row_next = o_tr;
            if (o_tc > max_col_next) max_col_next = o_tc;
            if (o_fc > max_col_next) max_col_next = o_fc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_row_reg <= '0;
            max_col_reg <= '0;
        end else if (q_push) begin
            max_row_reg <= max_row_next;
            max_col_reg <= max_col_next;
        end
    end

    // deltas and slope class
    assign drs   = (thlr_pkg::CW+1)'(o_tr) - (thlr_pkg::CW+1)'(o_fr);
    assign dcs   = (thlr_pkg::CW+1)'(o_tc) - (thlr_pkg::CW+1)'(o_fc);
    assign dr    = drs[thlr_pkg::CW-1:0];
    assign adc   = dcs[thlr_pkg::CW] ? thlr_pkg::CW'(-dcs) : dcs[thlr_pkg::CW-1:0];
    assign dr_q8 = {2'b00, dr, 8'h00};
    assign steep_p   = 22'(thlr_pkg::Q8_STEEP)   * 22'(adc);
    assign shallow_p = 22'(thlr_pkg::Q8_SHALLOW) * 22'(adc);

    // command word
    always_comb begin
        q_data.fr      = o_fr;
        q_data.fc      = o_fc;
        q_data.tr      = o_tr;
        q_data.tc      = o_tc;
        q_data.half    = line_width[3:1];
        q_data.addr    = read_addr;
        q_data.dr      = dr;
        q_data.adc     = adc;
        q_data.max_row = max_row_next;
        q_data.max_col = max_col_next;
        q_data.rstep   = dr_q8 < steep_p;
        if (dr_q8 > shallow_p)
            q_data.coff = dcs[thlr_pkg::CW] ? thlr_pkg::COFF_POS : thlr_pkg::COFF_NEG;
        else
            q_data.coff = thlr_pkg::COFF_NONE;
        priority if (s_tuser)
            q_data.kind = thlr_pkg::REQ_READ;
        else if (o_fc == o_tc)
            q_data.kind = thlr_pkg::SEG_VERT;
        else if (o_fr == o_tr)
            q_data.kind = thlr_pkg::SEG_HORZ;
        else
            q_data.kind = thlr_pkg::SEG_GEN;
    end

endmodule

// File: sv/thlr_fifo.sv
// ----------------------------------------------------------------------------
// thlr_fifo: short command queue between front and back
// Two entries; lets intake and drawing stall independently.
// ----------------------------------------------------------------------------
module thlr_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  thlr_pkg::cmd_t  push_data,
    input  logic            pop,
    output thlr_pkg::cmd_t  head,
    output logic            empty,
    output logic            full
);

    thlr_pkg::cmd_t                 mem_reg [thlr_pkg::FIFO_DEPTH];
    logic [thlr_pkg::FIFO_AW-1:0]   wp_reg, rp_reg;
    logic [thlr_pkg::FIFO_AW:0]     cnt_reg;

    assign empty = cnt_reg == '0;
    assign full  = cnt_reg == (thlr_pkg::FIFO_AW+1)'(thlr_pkg::FIFO_DEPTH);
    assign head  = mem_reg[rp_reg];

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
            if (push && !pop)      cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push) cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= push_data;
    end

endmodule

// File: sv/thlr_back.sv
// ----------------------------------------------------------------------------
// thlr_back: pixel walker, bitmap store and result register
// Clears the store after reset, then runs each command: bands and stepped
// copies at one pixel a cycle, or a single byte read.
// ----------------------------------------------------------------------------
module thlr_back #(
    parameter int ROWS          = 1024,
    parameter int BYTES_PER_ROW = 128,
    parameter int COLS          = 1024
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  thlr_pkg::cmd_t  head,
    input  logic            q_empty,
    output logic            q_pop,
    output logic            ready,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [31:0]     m_tdata,   // read_data, max_row_seen, max_col_seen
    output logic            m_tuser    // done_res
);

    localparam int STORE = ROWS * BYTES_PER_ROW;
    localparam int AW    = $clog2(STORE);
    localparam int PW    = thlr_pkg::PW;
    localparam int EW    = thlr_pkg::EW;

    thlr_pkg::back_state_t  state_reg, state_next;
    thlr_pkg::cmd_t         cur_reg, cur_next;
    logic signed [PW-1:0]   k_reg, k_next, i_reg, i_next;
    logic signed [PW-1:0]   r_reg, r_next, c_reg, c_next;
    logic signed [PW-1:0]   r1_reg, r1_next, c1_reg, c1_next;
    logic signed [EW-1:0]   e_reg, e_next;
    logic                   dxnz_reg, dxnz_next;
    logic [AW-1:0]          clr_reg, clr_next;

    logic                   plot_v;
    logic signed [PW-1:0]   plot_r, plot_c;
    logic                   pl_v_reg;
    logic signed [PW-1:0]   pl_r_reg, pl_c_reg;
    logic                   wr_en_reg;
    logic [AW-1:0]          wr_addr_reg;
    logic [2:0]             wr_bit_reg;
    logic                   in_range;

    logic [7:0]             mem [STORE];
    logic [7:0]             rd_q_reg;
    logic [AW-1:0]          rd_addr;

    logic                   out_v_reg, out_v_next;
    logic [7:0]             out_rd_reg, out_rd_next;
    logic signed [thlr_pkg::CW-1:0] out_mr_reg, out_mr_next, out_mc_reg, out_mc_next;

    logic signed [PW-1:0]   fr, fc, tr, tc, half_s;
    logic signed [PW-1:0]   bk_lo, bk_hi, bi_lo, bi_hi;
    logic signed [PW-1:0]   roff, coff;
    logic                   vert;

    assign fr     = PW'($signed(cur_reg.fr));
    assign fc     = PW'($signed(cur_reg.fc));
    assign tr     = PW'($signed(cur_reg.tr));
    assign tc     = PW'($signed(cur_reg.tc));
    assign half_s = $signed({{(PW-3){1'b0}}, cur_reg.half});
    assign vert   = cur_reg.kind == thlr_pkg::SEG_VERT;

    // band bounds: outer index k, inner index i
    always_comb begin
        if (vert) begin
            bk_lo = fc - half_s;
            bk_hi = fc + half_s;
            bi_lo = fr;
            bi_hi = tr;
        end else begin
            bk_lo = fr - half_s;
            bk_hi = fr + half_s;
            bi_lo = (fc < tc) ? fc : tc;
            bi_hi = (fc < tc) ? tc : fc;
        end
    end

    // offsets of the current parallel copy
    always_comb begin
        roff = cur_reg.rstep ? k_reg : '0;
        unique case (cur_reg.coff)
            thlr_pkg::COFF_POS: coff = k_reg;
            thlr_pkg::COFF_NEG: coff = -k_reg;
            default:            coff = '0;
        endcase
    end

    assign ready   = state_reg != thlr_pkg::BK_CLEAR;
    assign rd_addr = AW'(cur_reg.addr);

    // sequencer: next state, walker registers, plot request
    always_comb begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        k_next      = k_reg;
        i_next      = i_reg;
        r_next      = r_reg;
        c_next      = c_reg;
        r1_next     = r1_reg;
        c1_next     = c1_reg;
        e_next      = e_reg;
        dxnz_next   = dxnz_reg;
        clr_next    = clr_reg;
        q_pop       = 1'b0;
        plot_v      = 1'b0;
        plot_r      = r_reg;
        plot_c      = c_reg;
        out_v_next  = out_v_reg && !m_tready;
        out_rd_next = out_rd_reg;
        out_mr_next = out_mr_reg;
        out_mc_next = out_mc_reg;
        unique case (state_reg)
            thlr_pkg::BK_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(STORE - 1)) state_next = thlr_pkg::BK_IDLE;
            end
            thlr_pkg::BK_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    cur_next   = head;
                    state_next = thlr_pkg::BK_START;
                end
            end
            thlr_pkg::BK_START: begin
                unique case (cur_reg.kind)
                    thlr_pkg::SEG_VERT, thlr_pkg::SEG_HORZ: begin
                        k_next     = bk_lo;
                        i_next     = bi_lo;
                        state_next = thlr_pkg::BK_BAND;
                    end
                    thlr_pkg::SEG_GEN: begin
                        k_next     = -half_s;
                        state_next = thlr_pkg::BK_COPY;
                    end
                    default: state_next = thlr_pkg::BK_READ;
                endcase
            end
            thlr_pkg::BK_BAND: begin
                plot_v = 1'b1;
                plot_r = vert ? i_reg : k_reg;
                plot_c = vert ? k_reg : i_reg;
                if (i_reg == bi_hi) begin
                    i_next = bi_lo;
                    if (k_reg == bk_hi) state_next = thlr_pkg::BK_RESULT;
                    else                k_next = k_reg + 1'b1;
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
            thlr_pkg::BK_COPY: begin
                r_next     = fr + roff;
                c_next     = fc + coff;
                r1_next    = tr + roff;
                c1_next    = tc + coff;
                e_next     = '0;
                dxnz_next  = 1'b0;
                state_next = thlr_pkg::BK_WALK;
            end
            thlr_pkg::BK_WALK: begin
                if (r_reg < r1_reg || c_reg != c1_reg) begin
                    // e tracks dy*|dc| - dr*|dx|
                    if (!dxnz_reg || e_reg > 0) begin
                        c_next    = (c1_reg > c_reg) ? c_reg + 1'b1 : c_reg - 1'b1;
                        e_next    = e_reg - $signed({{(EW-thlr_pkg::CW){1'b0}}, cur_reg.dr});
                        dxnz_next = 1'b1;
                    end else begin
                        r_next = r_reg + 1'b1;
                        e_next = e_reg + $signed({{(EW-thlr_pkg::CW){1'b0}}, cur_reg.adc});
                    end
                    plot_v = 1'b1;
                    plot_r = r_next;
                    plot_c = c_next;
                end else if (k_reg == half_s) begin
                    state_next = thlr_pkg::BK_RESULT;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = thlr_pkg::BK_COPY;
                end
            end
            thlr_pkg::BK_READ: begin
                // rd_q_reg samples the addressed byte at this edge
                state_next = thlr_pkg::BK_RESULT;
            end
            thlr_pkg::BK_RESULT: begin
                if (!out_v_reg || m_tready) begin
                    out_v_next  = 1'b1;
                    out_mr_next = cur_reg.max_row;
                    out_mc_next = cur_reg.max_col;
                    if (cur_reg.kind == thlr_pkg::REQ_READ &&
                        32'(cur_reg.addr) < 32'(STORE))
                        out_rd_next = rd_q_reg;
                    else
                        out_rd_next = '0;
                    state_next = thlr_pkg::BK_IDLE;
                end
            end
            default: state_next = thlr_pkg::BK_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= thlr_pkg::BK_CLEAR;
            clr_reg   <= '0;
            out_v_reg <= 1'b0;
            pl_v_reg  <= 1'b0;
            wr_en_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            out_v_reg <= out_v_next;
            pl_v_reg  <= plot_v;
            wr_en_reg <= pl_v_reg && in_range;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cur_reg     <= cur_next;
        k_reg       <= k_next;
        i_reg       <= i_next;
        r_reg       <= r_next;
        c_reg       <= c_next;
        r1_reg      <= r1_next;
        c1_reg      <= c1_next;
        e_reg       <= e_next;
        dxnz_reg    <= dxnz_next;
        out_rd_reg  <= out_rd_next;
        out_mr_reg  <= out_mr_next;
        out_mc_reg  <= out_mc_next;
        pl_r_reg    <= plot_r;
        pl_c_reg    <= plot_c;
        wr_addr_reg <= AW'(pl_r_reg[PW-2:0]) * AW'(BYTES_PER_ROW) + AW'(pl_c_reg[PW-2:3]);
        wr_bit_reg  <= ~pl_c_reg[2:0];
    end

    // drop pixels outside the bitmap
    assign in_range = (pl_r_reg >= 0) && (pl_r_reg < $signed(PW'(ROWS))) &&
                      (pl_c_reg >= 0) && (pl_c_reg < $signed(PW'(COLS))) &&
                      ((pl_c_reg >>> 3) < $signed(PW'(BYTES_PER_ROW)));

    // bitmap store: one write port (clear or pixel set), one read port
    always_ff @(posedge aclk) begin
        if (state_reg == thlr_pkg::BK_CLEAR)
            mem[clr_reg] <= '0;
        else if (wr_en_reg)
            mem[wr_addr_reg][wr_bit_reg] <= 1'b1;
        rd_q_reg <= mem[rd_addr];
    end

    assign m_tvalid = out_v_reg;
    assign m_tuser  = 1'b1;
    assign m_tdata  = {out_mc_reg, out_mr_reg, out_rd_reg};

endmodule

// File: sv/thick_line_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// thick_line_rasterizer_unit: thick line drawing into a 1-bit bitmap
// Input words on the s_ channel are draw or read requests (tuser = 1 reads).
// Each request yields exactly one word on the m_ channel carrying the read
// byte (zero for a draw) and the largest row and column endpoints so far.
// Pixels are MSB first within a byte; row r, column c sits at byte
// r*BYTES_PER_ROW + c/8. Pixels outside the bitmap are dropped.
// Throughput: one pixel write per cycle while a band or a stepped copy
// is walked; each stepped copy also passes a setup state, and each request
// passes the idle, start and result states; a read goes through start,
// read and result before its word is offered.
// A two-word command queue sits between intake and the pixel walker, so new
// words are accepted while a drawing runs, until the queue fills.
// After reset the store is cleared one byte a cycle, all ROWS*BYTES_PER_ROW
// bytes, with s_tready low; maxima reset to zero.
// A stalled m_ side holds the result word; the walker waits in place and
// the queue then fills and drops s_tready.
// ----------------------------------------------------------------------------
module thick_line_rasterizer_unit #(
    parameter int ROWS          = 1024,
    parameter int BYTES_PER_ROW = 128,
    parameter int COLS          = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // from_row, from_col, to_row, to_col,
                                   // line_width, read_addr, zero pad
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_data, max_row_seen, max_col_seen
    output logic        m_tuser    // done_res
);

    thlr_pkg::cmd_t push_data, head;
    logic           push, pop, empty, full, back_ready;

    thlr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .q_full     (full),
        .back_ready (back_ready),
        .q_push     (push),
        .q_data     (push_data)
    );

    thlr_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    thlr_back #(
        .ROWS          (ROWS),
        .BYTES_PER_ROW (BYTES_PER_ROW),
        .COLS          (COLS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_empty  (empty),
        .q_pop    (pop),
        .ready    (back_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the thick line rasterizer
// Drives draw and read request words into thick_line_rasterizer_unit and
// checks every result word against a local bitmap painter that tracks the
// store and the running maxima (typed directed rows give fixed values). A
// short directed table covers reset state, point, band, stepped and clipped
// segments; random traffic follows, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb;

    localparam int ROWS          = 1024;
    localparam int BYTES_PER_ROW = 128;
    localparam int COLS          = 1024;
    localparam int STORE_BYTES   = ROWS * BYTES_PER_ROW;
    localparam int N_RANDOM      = 1730;
    localparam longint LIMIT     = 8000000;

    localparam logic REQ_DRAW = 1'b0;
    localparam logic REQ_RD   = 1'b1;

    typedef struct {
        logic        kind;
        int          fr, fc, tr, tc, w, addr;
        bit          typed;
        logic [7:0]  t_data;
        int          t_row, t_col;
    } stim_row_t;

    typedef struct {
        logic [7:0]  data;
        logic [11:0] mrow;
        logic [11:0] mcol;
    } result_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    logic [7:0]     bitmap [0:STORE_BYTES-1];
    int             peak_row, peak_col;
    result_word_t   pending_results[$];
    stim_row_t      directed[$];
    int             fails = 0;
    longint         cycles = 0;
    bit             quiet = 1'b0;
    int             stall_left = 0;

    thick_line_rasterizer_unit #(
        .ROWS(ROWS), .BYTES_PER_ROW(BYTES_PER_ROW), .COLS(COLS)
    ) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #1 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // ---------------- bitmap painter ----------------
    function automatic int sgn(int x);
        return (x > 0) ? 1 : ((x < 0) ? -1 : 0);
    endfunction

    function automatic int absv(int x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic void set_pixel(int r, int c);
        int idx;
        if (r < 0 || r >= ROWS || c < 0 || c >= COLS) return;
        if ((c >>> 3) >= BYTES_PER_ROW) return;
        idx = (c >>> 3) + BYTES_PER_ROW * r;
        bitmap[idx] = bitmap[idx] | (8'h80 >> (c & 7));
    endfunction

    function automatic void paint_segment(int fr, int fc, int tr, int tc, int w);
        int half, t, dr, dc, adc, s, rstep, cstep;
        int r0, c0, r1, c1, r, c, dx, dy, lo, hi;
        half = w / 2;
        if (tr < fr) begin
            t = fr; fr = tr; tr = t;
            t = fc; fc = tc; tc = t;
        end
        if (tr > peak_row) peak_row = tr;
        if (tc > peak_col) peak_col = tc;
        if (fc > peak_col) peak_col = fc;
        // vertical band, single point included
        if (fc == tc) begin
            for (int k = fc - half; k <= fc + half; k++)
                for (int i = fr; i <= tr; i++) set_pixel(i, k);
            return;
        end
        // horizontal band
        if (fr == tr) begin
            lo = (fc < tc) ? fc : tc;
            hi = (fc < tc) ? tc : fc;
            for (int k = fr - half; k <= fr + half; k++)
                for (int i = lo; i <= hi; i++) set_pixel(k, i);
            return;
        end
        // stepped copies, offset by slope class
        dr = tr - fr;
        dc = tc - fc;
        adc = absv(dc);
        s = sgn(dc);
        rstep = (dr * 256 < thlr_pkg::Q8_STEEP * adc) ? 1 : 0;
        cstep = (dr * 256 > thlr_pkg::Q8_SHALLOW * adc) ? -s : 0;
        for (int k = -half; k <= half; k++) begin
            r0 = fr + k * rstep; c0 = fc + k * cstep;
            r1 = tr + k * rstep; c1 = tc + k * cstep;
            r = r0; c = c0;
            while (r < r1 || c != c1) begin
                dx = c - c0;
                if (dx != 0) begin
                    dy = r - r0;
                    if (dy * adc > dr * absv(dx)) c += sgn(c1 - c);
                    else r += sgn(r1 - r);
                end else begin
                    c += sgn(c1 - c);
                end
                set_pixel(r, c);
            end
        end
    endfunction

    function automatic result_word_t serve_request(stim_row_t q);
        result_word_t res;
        res.data = 8'h00;
        if (q.kind == REQ_DRAW) paint_segment(q.fr, q.fc, q.tr, q.tc, q.w);
        else if (q.addr < STORE_BYTES) res.data = bitmap[q.addr];
        res.mrow = peak_row[11:0];
        res.mcol = peak_col[11:0];
        return res;
    endfunction

    // ---------------- sender ----------------
    task automatic send_word(stim_row_t q, bit may_idle);
        result_word_t res;
        int gap;
        gap = (may_idle && !quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= q.kind;
        s_tdata  <= {3'b000, q.addr[16:0], q.w[3:0], q.tc[11:0], q.tr[11:0],
                     q.fc[11:0], q.fr[11:0]};
        do @(posedge aclk); while (!s_tready);
        res = serve_request(q);
        if (q.typed) begin
            res.data = q.t_data;
            res.mrow = q.t_row[11:0];
            res.mcol = q.t_col[11:0];
        end
        pending_results.push_back(res);
    endtask

    function automatic stim_row_t mk(logic kind, int fr, int fc, int tr, int tc, int w,
                                     int addr);
        stim_row_t q;
        q.kind = kind; q.fr = fr; q.fc = fc; q.tr = tr; q.tc = tc; q.w = w;
        q.addr = addr; q.typed = 1'b0; q.t_data = 8'h00; q.t_row = 0; q.t_col = 0;
        return q;
    endfunction

    function automatic stim_row_t mk_typed(int addr, logic [7:0] d, int r, int c);
        stim_row_t q;
        q = mk(REQ_RD, 0, 0, 0, 0, 0, addr);
        q.typed = 1'b1; q.t_data = d; q.t_row = r; q.t_col = c;
        return q;
    endfunction

    function automatic int sx12(int v);
        logic signed [11:0] x;
        x = v[11:0];
        return int'(x);
    endfunction

    function automatic stim_row_t random_word();
        stim_row_t q;
        int sel, dr, dc;
        q = mk(REQ_DRAW, 0, 0, 0, 0, 0, 0);
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
            q.kind = REQ_RD;
            if ($urandom_range(0, 4) != 0)
                q.addr = $urandom_range(0, 300) * BYTES_PER_ROW + $urandom_range(0, 40);
            else
                q.addr = $urandom_range(0, 131071);
        end else begin
            if (sel < 98) begin
                q.fr = $urandom_range(0, 300) - 10;
                q.fc = $urandom_range(0, 320) - 10;
                if ($urandom_range(0, 9) == 0) begin
                    q.fr = q.fr + 900; q.fc = q.fc + 900;
                end
            end else begin
                q.fr = sx12($urandom_range(0, 4095));
                q.fc = sx12($urandom_range(0, 4095));
            end
            dr = $urandom_range(0, 40) - 20;
            dc = $urandom_range(0, 40) - 20;
            if ($urandom_range(0, 5) == 0) dr = 0;
            else if ($urandom_range(0, 5) == 0) dc = 0;
            q.tr = q.fr + dr;
            q.tc = q.fc + dc;
            if (sel >= 98) begin
                q.tr = sx12($urandom_range(0, 4095));
                q.tc = sx12($urandom_range(0, 4095));
            end
            q.tr = sx12(q.tr); q.tc = sx12(q.tc);
            q.w = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 15);
            if (sel >= 98) q.w = $urandom_range(0, 1);
            q.addr = $urandom_range(0, 131071);
        end
        return q;
    endfunction

    // ---------------- result checker ----------------
    always @(posedge aclk) begin
        result_word_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result word %h", m_tdata);
                fails++;
            end else begin
                e = pending_results.pop_front();
                if (m_tuser !== 1'b1) begin
                    $error("done_res exp 1 got %b", m_tuser);
                    fails++;
                end
                if (m_tdata[7:0] !== e.data) begin
                    $error("read_data exp %h got %h", e.data, m_tdata[7:0]);
                    fails++;
                end
                if (m_tdata[19:8] !== e.mrow) begin
                    $error("max_row_seen exp %h got %h", e.mrow, m_tdata[19:8]);
                    fails++;
                end
                if (m_tdata[31:20] !== e.mcol) begin
                    $error("max_col_seen exp %h got %h", e.mcol, m_tdata[31:20]);
                    fails++;
                end
            end
        end
    end

    // receiver drops m_tready in random bursts
    always @(negedge aclk) begin
        if (quiet) begin
            m_tready <= 1'b1;
        end else if (!m_tready && stall_left > 0) begin
            stall_left = stall_left - 1;
        end else if (!m_tready) begin
            m_tready <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(0, 3);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ---------------- main sequence ----------------
    initial begin
        stim_row_t q;
        for (int i = 0; i < STORE_BYTES; i++) bitmap[i] = 8'h00;
        peak_row = 0;
        peak_col = 0;

        // directed table
        directed.push_back(mk_typed(0, 8'h00, 0, 0));           // store clear after reset
        directed.push_back(mk(REQ_DRAW, 3, 9, 3, 9, 0, 0));      // single point
        directed.push_back(mk_typed(385, 8'h40, 3, 9));
        directed.push_back(mk(REQ_DRAW, 10, 20, 30, 20, 5, 0));  // vertical band
        directed.push_back(mk(REQ_DRAW, 40, 50, 40, 10, 4, 0));  // horizontal band
        directed.push_back(mk(REQ_DRAW, 60, 5, 100, 15, 3, 0));  // steep
        directed.push_back(mk(REQ_DRAW, 70, 80, 75, 10, 6, 0));  // shallow, negative slope
        directed.push_back(mk(REQ_DRAW, 120, 30, 100, 50, 7, 0)); // diagonal, swapped
        directed.push_back(mk(REQ_DRAW, 130, 0, 150, 9, 15, 0)); // widest, near left edge
        directed.push_back(mk(REQ_DRAW, -5, -5, 6, 4, 2, 0));    // clipped at origin
        directed.push_back(mk(REQ_DRAW, 1020, 1018, 1030, 1030, 3, 0)); // clipped far edge
        directed.push_back(mk(REQ_DRAW, -2048, -2048, 2047, 2047, 0, 0));
        directed.push_back(mk(REQ_DRAW, 2047, -2048, -2048, 2047, 1, 0));
        directed.push_back(mk(REQ_DRAW, -2048, 5, 2047, 5, 0, 0));
        directed.push_back(mk(REQ_DRAW, 7, 2047, 7, -2048, 0, 0));
        directed.push_back(mk(REQ_RD, 0, 0, 0, 0, 0, 131071));
        for (int a = 0; a < 6; a++) begin
            directed.push_back(mk(REQ_RD, 0, 0, 0, 0, 0, 64 * BYTES_PER_ROW + a));
            directed.push_back(mk(REQ_RD, 0, 0, 0, 0, 0, 20 * BYTES_PER_ROW + 2 + a));
        end

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) send_word(directed[i], 1'b1);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) begin
                // hold off until the block has drained
                @(negedge aclk);
                s_tvalid <= 1'b0;
                while (pending_results.size() != 0) @(posedge aclk);
            end
            if (n == N_RANDOM - 150) quiet = 1'b1;
            q = random_word();
            send_word(q, 1'b1);
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (fails == 0) $display("tb: PASS");
        else $display("tb: FAIL");
        $finish;
    end

endmodule
